// ===== rtl/qis_pkg.sv =====
// ----------------------------------------------------------------------------
// qis_pkg
// Shared constants and types of the quantized int8 swish block: register
// map, reset values and the widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
package qis_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // series terms of e^-y and squarings that follow
    localparam int N_TERMS  = 13;
    localparam int N_SQUARE = 4;

    // sigmoid divider: 17 quotient bits, Q0.16 with 1.0 included
    localparam int SIG_Q_BITS = 17;
    localparam int SIG_NUM_W  = 50;
    localparam int SIG_DEN_W  = 34;

    // output divider quotient bits below the saturation check
    localparam int OUT_Q_BITS = 8;

    localparam logic [31:0]        SCALE_RST = 32'h0100_0000;
    localparam logic signed [33:0] ONE_Q32   = 34'sh1_0000_0000;
    localparam logic [16:0]        SIG_ONE   = 17'h1_0000;

    typedef enum logic [1:0] {
        REG_IN_SCALE  = 2'd0,
        REG_IN_ZERO   = 2'd1,
        REG_OUT_SCALE = 2'd2,
        REG_OUT_ZERO  = 2'd3
    } t_reg_idx;

endpackage

// ===== rtl/quantized_int8_swish.sv =====
// An accepted input item passes 73 registers, counting the output buffer,
// on its way to o_out_code. Throughput: one item per cycle while the
// output buffer is not full; 72 pipeline stages, most of them in the 12
// series steps of e^-y (multiply, reciprocal multiply, correction) and in
// two restoring dividers that resolve one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and restores registers.
// ----------------------------------------------------------------------------
// quantized_int8_swish
// Quantized int8 swish activation: dequantize, x*sigmoid(x), requantize with
// rounding half away from zero, add output zero point and saturate.
// ----------------------------------------------------------------------------
module quantized_int8_swish #(
    parameter int FRAC_BITS = qis_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_code,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_code,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qis_pkg::*;

    localparam int XW    = 17 + FRAC_BITS;
    localparam int NUMW  = XW + SIG_Q_BITS;
    localparam int DENW  = 24 + FRAC_BITS;
    localparam int NQW   = NUMW + 2;
    localparam int DQW   = DENW + 1;
    localparam int NSTEP = N_TERMS - 1;

    typedef struct packed {
        logic          neg;
        logic          sat16;
        logic [XW-1:0] xm;
    } t_ctx;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_in_scale, r_out_scale;
    logic [7:0]  r_in_zero, r_out_zero;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_scale  <= SCALE_RST;
            r_in_zero   <= 8'd0;
            r_out_scale <= SCALE_RST;
            r_out_zero  <= 8'd0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_IN_SCALE:  r_in_scale  <= pwdata;
                REG_IN_ZERO:   r_in_zero   <= pwdata[7:0];
                REG_OUT_SCALE: r_out_scale <= pwdata;
                REG_OUT_ZERO:  r_out_zero  <= pwdata[7:0];
                default:       r_in_zero   <= r_in_zero;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_IN_SCALE:  prdata = r_in_scale;
            REG_IN_ZERO:   prdata = {{24{r_in_zero[7]}}, r_in_zero};
            REG_OUT_SCALE: prdata = r_out_scale;
            REG_OUT_ZERO:  prdata = {{24{r_out_zero[7]}}, r_out_zero};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline enable from the output buffer fill
    // ------------------------------------------------------------------
    logic [1:0] r_cnt;
    logic       en;

    assign en         = (r_cnt != 2'd2);
    assign o_in_ready = en;

    // ------------------------------------------------------------------
    // stage 1: offset and scale product
    // ------------------------------------------------------------------
    logic signed [8:0] s1_d;
    logic [7:0]        s1_mag;
    logic              r1_v, r1_neg;
    logic [39:0]       r1_prod;

    assign s1_d   = $signed({i_in_code[7], i_in_code}) - $signed({r_in_zero[7], r_in_zero});
    assign s1_mag = s1_d[8] ? 8'(-s1_d) : s1_d[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_neg  <= s1_d[8];
            r1_prod <= 40'(r_in_scale) * 40'(s1_mag);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: round to FRAC_BITS, series argument
    // ------------------------------------------------------------------
    logic [41:0]   s2_tmp;
    logic [XW-1:0] s2_xm;
    logic          r2_v;
    t_ctx          r2_ctx;
    logic [31:0]   r2_y;

    assign s2_tmp = (42'({r1_prod, 1'b0}) >> (24 - FRAC_BITS)) + 42'd1;
    assign s2_xm  = s2_tmp[XW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctx.neg   <= r1_neg;
            r2_ctx.xm    <= s2_xm;
            r2_ctx.sat16 <= (s2_xm >= (XW'(16) << FRAC_BITS));
            // y = |x|/16 in Q0.32, only meaningful below 16
            r2_y         <= 32'(s2_xm[FRAC_BITS+3:0]) << (28 - FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // series of e^-y: three stages per term
    // ------------------------------------------------------------------
    logic                r_ta_v   [NSTEP];
    t_ctx                r_ta_ctx [NSTEP];
    logic [31:0]         r_ta_y   [NSTEP];
    logic signed [33:0]  r_ta_acc [NSTEP];
    logic [31:0]         r_ta_p   [NSTEP];

    logic                r_tb_v   [NSTEP];
    t_ctx                r_tb_ctx [NSTEP];
    logic [31:0]         r_tb_y   [NSTEP];
    logic signed [33:0]  r_tb_acc [NSTEP];
    logic [31:0]         r_tb_pv  [NSTEP];
    logic [31:0]         r_tb_q   [NSTEP];

    logic                r_tc_v   [NSTEP];
    t_ctx                r_tc_ctx [NSTEP];
    logic [31:0]         r_tc_y   [NSTEP];
    logic signed [33:0]  r_tc_acc [NSTEP];
    logic [31:0]         r_tc_t   [NSTEP];

    for (genvar j = 0; j < NSTEP; j++) begin : g_term
        localparam int          K        = j + 2;
        localparam logic [33:0] RECIP    = 34'((64'd1 << 34) / K);
        // the previous term is subtracted when its index is odd
        localparam bit          SUB_PREV = ((j % 2) == 0);

        logic               a_v;
        t_ctx               a_ctx;
        logic [31:0]        a_y, a_t, c_rem;
        logic signed [33:0] a_acc;

        if (j == 0) begin : g_first
            assign a_v   = r2_v;
            assign a_ctx = r2_ctx;
            assign a_y   = r2_y;
            assign a_t   = r2_y;
            assign a_acc = ONE_Q32;
        end else begin : g_next
            assign a_v   = r_tc_v[j-1];
            assign a_ctx = r_tc_ctx[j-1];
            assign a_y   = r_tc_y[j-1];
            assign a_t   = r_tc_t[j-1];
            assign a_acc = r_tc_acc[j-1];
        end

        assign c_rem = r_tb_pv[j] - (r_tb_q[j] * 32'(K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ta_v[j] <= 1'b0;
                r_tb_v[j] <= 1'b0;
                r_tc_v[j] <= 1'b0;
            end else if (en) begin
                r_ta_v[j] <= a_v;
                r_tb_v[j] <= r_ta_v[j];
                r_tc_v[j] <= r_tb_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ta_ctx[j] <= a_ctx;
                r_ta_y[j]   <= a_y;
                r_ta_acc[j] <= SUB_PREV ? a_acc - $signed(34'(a_t)) : a_acc + $signed(34'(a_t));
                r_ta_p[j]   <= 32'((64'(a_t) * 64'(a_y)) >> 32);

                r_tb_ctx[j] <= r_ta_ctx[j];
                r_tb_y[j]   <= r_ta_y[j];
                r_tb_acc[j] <= r_ta_acc[j];
                r_tb_pv[j]  <= r_ta_p[j];
                // estimate may fall one short of the true quotient
                r_tb_q[j]   <= 32'((66'(r_ta_p[j]) * 66'(RECIP)) >> 34);

                r_tc_ctx[j] <= r_tb_ctx[j];
                r_tc_y[j]   <= r_tb_y[j];
                r_tc_acc[j] <= r_tb_acc[j];
                r_tc_t[j]   <= r_tb_q[j] + 32'(c_rem >= 32'(K));
            end
        end
    end

    // ------------------------------------------------------------------
    // last term and clamp at zero
    // ------------------------------------------------------------------
    logic signed [33:0] e_acc;
    logic               r_e_v;
    t_ctx               r_e_ctx;
    logic [32:0]        r_e;

    assign e_acc = r_tc_acc[NSTEP-1] - $signed(34'(r_tc_t[NSTEP-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_tc_v[NSTEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_ctx <= r_tc_ctx[NSTEP-1];
            r_e     <= e_acc[33] ? 33'd0 : e_acc[32:0];
        end
    end

    // ------------------------------------------------------------------
    // four squarings: e^-16y
    // ------------------------------------------------------------------
    logic        r_sq_v   [N_SQUARE];
    t_ctx        r_sq_ctx [N_SQUARE];
    logic [31:0] r_sq     [N_SQUARE];

    for (genvar s = 0; s < N_SQUARE; s++) begin : g_sq
        logic        q_v;
        t_ctx        q_ctx;
        logic [31:0] q_e;

        if (s == 0) begin : g_first
            assign q_v   = r_e_v;
            assign q_ctx = r_e_ctx;
            assign q_e   = r_e[32] ? 32'hFFFF_FFFF : r_e[31:0];
        end else begin : g_next
            assign q_v   = r_sq_v[s-1];
            assign q_ctx = r_sq_ctx[s-1];
            assign q_e   = r_sq[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[s] <= 1'b0;
            end else if (en) begin
                r_sq_v[s] <= q_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_ctx[s] <= q_ctx;
                r_sq[s]     <= 32'((64'(q_e) * 64'(q_e)) >> 32);
            end
        end
    end

    // ------------------------------------------------------------------
    // sigmoid divider: (2^49 + d) / 2d, d = 2^32 + e, one bit per stage
    // ------------------------------------------------------------------
    logic                   r_sd_v   [SIG_Q_BITS];
    t_ctx                   r_sd_ctx [SIG_Q_BITS];
    logic [SIG_NUM_W-1:0]   r_sd_rem [SIG_Q_BITS];
    logic [SIG_DEN_W-1:0]   r_sd_den [SIG_Q_BITS];
    logic [SIG_Q_BITS-1:0]  r_sd_q   [SIG_Q_BITS];

    for (genvar s = 0; s < SIG_Q_BITS; s++) begin : g_sdiv
        localparam int BIT = SIG_Q_BITS - 1 - s;

        logic                  d_v;
        t_ctx                  d_ctx;
        logic [SIG_NUM_W-1:0]  d_rem, d_sh;
        logic [SIG_DEN_W-1:0]  d_den;
        logic [SIG_Q_BITS-1:0] d_q;

        if (s == 0) begin : g_first
            assign d_v   = r_sq_v[N_SQUARE-1];
            assign d_ctx = r_sq_ctx[N_SQUARE-1];
            assign d_rem = {1'b1, 16'd0, 1'b1, r_sq[N_SQUARE-1]};
            assign d_den = {1'b1, r_sq[N_SQUARE-1], 1'b0};
            assign d_q   = '0;
        end else begin : g_next
            assign d_v   = r_sd_v[s-1];
            assign d_ctx = r_sd_ctx[s-1];
            assign d_rem = r_sd_rem[s-1];
            assign d_den = r_sd_den[s-1];
            assign d_q   = r_sd_q[s-1];
        end

        assign d_sh = SIG_NUM_W'(d_den) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd_v[s] <= 1'b0;
            end else if (en) begin
                r_sd_v[s] <= d_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd_ctx[s] <= d_ctx;
                r_sd_den[s] <= d_den;
                if (d_rem >= d_sh) begin
                    r_sd_rem[s] <= d_rem - d_sh;
                    r_sd_q[s]   <= d_q | (SIG_Q_BITS'(1) << BIT);
                end else begin
                    r_sd_rem[s] <= d_rem;
                    r_sd_q[s]   <= d_q;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // signed sigmoid, product, requantize numerator and denominator
    // ------------------------------------------------------------------
    logic [16:0]   sg_sp;
    logic          r_sg_v, r_sg_neg;
    logic [XW-1:0] r_sg_xm;
    logic [16:0]   r_sg;

    assign sg_sp = r_sd_ctx[SIG_Q_BITS-1].sat16 ? SIG_ONE : r_sd_q[SIG_Q_BITS-1];

    logic            r_mu_v, r_mu_neg;
    logic [NUMW-1:0] r_mu_num;

    logic [31:0]     os_eff;
    logic [DENW-1:0] nq_den;
    logic            r_nq_v, r_nq_neg;
    logic [NQW-1:0]  r_nq_n;
    logic [DQW-1:0]  r_nq_d;

    assign os_eff = (r_out_scale == 32'd0) ? 32'd1 : r_out_scale;
    assign nq_den = DENW'(os_eff) << (FRAC_BITS - 8);

    logic           r_st_v, r_st_neg, r_st_sat;
    logic [NQW-1:0] r_st_n;
    logic [DQW-1:0] r_st_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg_v <= 1'b0;
            r_mu_v <= 1'b0;
            r_nq_v <= 1'b0;
            r_st_v <= 1'b0;
        end else if (en) begin
            r_sg_v <= r_sd_v[SIG_Q_BITS-1];
            r_mu_v <= r_sg_v;
            r_nq_v <= r_mu_v;
            r_st_v <= r_nq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sg_neg <= r_sd_ctx[SIG_Q_BITS-1].neg;
            r_sg_xm  <= r_sd_ctx[SIG_Q_BITS-1].xm;
            r_sg     <= r_sd_ctx[SIG_Q_BITS-1].neg ? SIG_ONE - sg_sp : sg_sp;

            r_mu_neg <= r_sg_neg;
            r_mu_num <= NUMW'(r_sg_xm) * NUMW'(r_sg);

            r_nq_neg <= r_mu_neg;
            r_nq_n   <= (NQW'(r_mu_num) << 1) + NQW'(nq_den);
            r_nq_d   <= DQW'(nq_den) << 1;

            r_st_neg <= r_nq_neg;
            r_st_n   <= r_nq_n;
            r_st_d   <= r_nq_d;
            r_st_sat <= (r_nq_n >= (NQW'(r_nq_d) << OUT_Q_BITS));
        end
    end

    // ------------------------------------------------------------------
    // output divider, eight quotient bits
    // ------------------------------------------------------------------
    logic                  r_od_v   [OUT_Q_BITS];
    logic                  r_od_neg [OUT_Q_BITS];
    logic                  r_od_sat [OUT_Q_BITS];
    logic [NQW-1:0]        r_od_rem [OUT_Q_BITS];
    logic [DQW-1:0]        r_od_d   [OUT_Q_BITS];
    logic [OUT_Q_BITS-1:0] r_od_q   [OUT_Q_BITS];

    for (genvar s = 0; s < OUT_Q_BITS; s++) begin : g_odiv
        localparam int BIT = OUT_Q_BITS - 1 - s;

        logic                  o_v, o_neg, o_sat;
        logic [NQW-1:0]        o_rem, o_sh;
        logic [DQW-1:0]        o_d;
        logic [OUT_Q_BITS-1:0] o_q;

        if (s == 0) begin : g_first
            assign o_v   = r_st_v;
            assign o_neg = r_st_neg;
            assign o_sat = r_st_sat;
            assign o_rem = r_st_n;
            assign o_d   = r_st_d;
            assign o_q   = '0;
        end else begin : g_next
            assign o_v   = r_od_v[s-1];
            assign o_neg = r_od_neg[s-1];
            assign o_sat = r_od_sat[s-1];
            assign o_rem = r_od_rem[s-1];
            assign o_d   = r_od_d[s-1];
            assign o_q   = r_od_q[s-1];
        end

        assign o_sh = NQW'(o_d) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_od_v[s] <= 1'b0;
            end else if (en) begin
                r_od_v[s] <= o_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_od_neg[s] <= o_neg;
                r_od_sat[s] <= o_sat;
                r_od_d[s]   <= o_d;
                if (o_rem >= o_sh) begin
                    r_od_rem[s] <= o_rem - o_sh;
                    r_od_q[s]   <= o_q | (OUT_Q_BITS'(1) << BIT);
                end else begin
                    r_od_rem[s] <= o_rem;
                    r_od_q[s]   <= o_q;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // zero point, clamp and output buffer
    // ------------------------------------------------------------------
    logic [7:0]        f_q;
    logic signed [9:0] f_sum;
    logic [7:0]        f_code;
    logic              push, pop;
    logic [7:0]        r_b0, r_b1;

    assign f_q   = r_od_sat[OUT_Q_BITS-1] ? 8'hFF : r_od_q[OUT_Q_BITS-1];
    assign f_sum = r_od_neg[OUT_Q_BITS-1]
                   ? $signed({{2{r_out_zero[7]}}, r_out_zero}) - $signed({2'b00, f_q})
                   : $signed({{2{r_out_zero[7]}}, r_out_zero}) + $signed({2'b00, f_q});

    always_comb begin
        if (f_sum > 10'sd127) begin
            f_code = 8'h7F;
        end else if (f_sum < -10'sd128) begin
            f_code = 8'h80;
        end else begin
            f_code = f_sum[7:0];
        end
    end

    assign push        = r_od_v[OUT_Q_BITS-1] & en;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid & i_out_ready;
    assign o_out_code  = r_b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_b0 <= f_code;
        end else if (pop && r_cnt == 2'd2) begin
            r_b0 <= r_b1;
        end
        if (push && r_cnt == 2'd1 && !pop) begin
            r_b1 <= f_code;
        end
    end

`ifndef ASSERT_OFF
    a_buf_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer fill out of range");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> (r_e <= 33'h1_0000_0000))
        else $error("series result above one");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd_v[SIG_Q_BITS-1] |-> (r_sd_q[SIG_Q_BITS-1] <= SIG_ONE))
        else $error("sigmoid quotient above one");

    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1 && pop && !push) |=> !o_out_valid)
        else $error("item repeated after last pop");
`endif

endmodule
